FILE: rtl/ffr_pkg.sv
// Shared types and constants for the feedback frame receiver.
// No dependencies; imported by every module in rtl/.
package ffr_pkg;

	localparam int unsigned FrameLen   = 18;
	localparam int unsigned NumPayload = 7;
	localparam int unsigned IdxW       = 5;

	localparam logic [IdxW-1:0] IdxIdle  = 5'd0;
	localparam logic [IdxW-1:0] IdxFirst = 5'd2;
	localparam logic [IdxW-1:0] IdxLast  = 5'(FrameLen - 1);

	localparam logic [15:0] StartWordRst = 16'hABCD;

	// frame as assembled by the front end, not yet checked
	typedef struct packed {
		logic [15:0]                 first_word;
		logic [15:0]                 check_word;
		logic [15:0]                 xor_sum;
		logic [NumPayload-1:0][15:0] payload;
	} frame_rec_t;

	// checked result as presented on the output ports
	typedef struct packed {
		logic                        frame_valid;
		logic [NumPayload-1:0][15:0] payload;
	} frame_res_t;

endpackage

FILE: rtl/ffr_front.sv
// Front end: byte joining, start word detection and frame assembly.
// Keeps a running XOR of words 0..7; depends on ffr_pkg.
module ffr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         rx_byte,
	input  logic [15:0]        start_word,
	output logic               rec_push,
	output ffr_pkg::frame_rec_t rec
);
	import ffr_pkg::*;

	logic [7:0]      prev_q;
	logic [IdxW-1:0] idx_q;
	logic [7:0]      lo_q;
	logic [15:0]     word0_q;
	logic [15:0]     xor_q;
	logic [NumPayload-1:0][15:0] word_q;

	logic [15:0] joined;
	logic [15:0] pair;
	logic        match;
	logic        assembling;
	logic        hi_byte;

	assign joined     = {rx_byte, prev_q};
	assign pair       = {rx_byte, lo_q};
	assign match      = (joined == start_word);
	assign assembling = (idx_q != IdxIdle);
	assign hi_byte    = idx_q[0];

	assign rec_push = accept && !match && (idx_q == IdxLast);

	always_comb begin
		rec.first_word = word0_q;
		rec.check_word = pair;
		rec.xor_sum    = xor_q;
		rec.payload    = word_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			idx_q  <= IdxIdle;
		end else if (accept) begin
			prev_q <= rx_byte;
			if (match) begin
				idx_q <= IdxFirst;
			end else if (rec_push) begin
				idx_q <= IdxIdle;
			end else if (assembling) begin
				idx_q <= idx_q + 5'd1;
			end
		end
	end

	// frame storage, written before it is read
	always_ff @(posedge clk) begin
		if (accept) begin
			if (match) begin
				word0_q <= joined;
				xor_q   <= joined;
			end else if (assembling) begin
				if (!hi_byte) begin
					lo_q <= rx_byte;
				end else if (idx_q != IdxLast) begin
					xor_q <= xor_q ^ pair;
				end
				for (int k = 0; k < NumPayload; k++) begin
					if (hi_byte && idx_q[IdxW-1:1] == 4'(k + 1)) begin
						word_q[k] <= pair;
					end
				end
			end
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 5'd1 && idx_q <= IdxLast)
		else $error("frame index out of range");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && match |=> idx_q == IdxFirst && !$past(rec_push))
		else $error("start word did not restart assembly");

endmodule

FILE: rtl/ffr_queue.sv
// Short queue of assembled frames between front and back end.
// Register array with one read port; depends on ffr_pkg.
module ffr_queue #(
	parameter int unsigned Depth = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  ffr_pkg::frame_rec_t wr_data,
	output logic                full,
	input  logic                rd_en,
	output logic                not_empty,
	output ffr_pkg::frame_rec_t rd_data
);
	import ffr_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

	frame_rec_t          mem_q [Depth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     count_q;

	assign full      = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CntW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full) && !(rd_en && !not_empty))
		else $error("frame queue overrun or underrun");

endmodule

FILE: rtl/ffr_back.sv
// Back end: start word and checksum check, output register.
// Drains the frame queue; depends on ffr_pkg.
module ffr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         start_word,
	input  logic                rec_avail,
	input  ffr_pkg::frame_rec_t rec,
	output logic                rec_take,
	output logic                empty,
	input  logic                pop,
	output ffr_pkg::frame_res_t res
);
	import ffr_pkg::*;

	logic       out_v_q;
	frame_res_t res_q;
	logic       ok;

	assign ok       = (rec.first_word == start_word) && (rec.xor_sum == rec.check_word);
	assign rec_take = rec_avail && (!out_v_q || pop);
	assign empty    = !out_v_q;
	assign res      = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rec_take) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	// dropped frames report all-zero payload
	always_ff @(posedge clk) begin
		if (rec_take) begin
			res_q.frame_valid <= ok;
			res_q.payload     <= ok ? rec.payload : '0;
		end
	end

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !res_q.frame_valid |-> res_q.payload == '0)
		else $error("dropped frame carries payload");

endmodule

FILE: rtl/feedback_frame_receiver.sv
// Feedback frame receiver: one byte per cycle in while full is low, one checked frame per 18-byte frame out.
// Frame path: a frame enters the frame queue at the edge that takes its last byte, then moves
// into the output register when the output register is free or is being popped.
// Throughput: one byte every cycle while full is low; full rises only when the frame queue holds
// QueueDepth frames and the output register is occupied.
// Reset (arst_n low, async): idle, no frame in flight, queue and output empty,
// start_word back to 0xABCD. Depends on ffr_pkg, ffr_front, ffr_queue, ffr_back.
module feedback_frame_receiver #(
	parameter int unsigned QueueDepth = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         rx_byte,
	output logic               empty,
	input  logic               pop,
	output logic               frame_valid,
	output logic signed [15:0] command_one,
	output logic signed [15:0] command_two,
	output logic signed [15:0] speed_right,
	output logic signed [15:0] speed_left,
	output logic signed [15:0] battery_voltage,
	output logic signed [15:0] board_temperature,
	output logic [15:0]        led_command,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);
	import ffr_pkg::*;

	logic        cfg_wr;
	logic [15:0] start_q;
	logic        accept;
	logic        rec_push;
	logic        rec_take;
	logic        rec_avail;
	frame_rec_t  rec_in;
	frame_rec_t  rec_out;
	frame_res_t  res;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= StartWordRst;
		end else if (cfg_wr) begin
			start_q <= cfg_data;
		end
	end

	ffr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (rx_byte),
		.start_word (start_q),
		.rec_push   (rec_push),
		.rec        (rec_in)
	);

	ffr_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (rec_push),
		.wr_data   (rec_in),
		.full      (full),
		.rd_en     (rec_take),
		.not_empty (rec_avail),
		.rd_data   (rec_out)
	);

	ffr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.start_word (start_q),
		.rec_avail  (rec_avail),
		.rec        (rec_out),
		.rec_take   (rec_take),
		.empty      (empty),
		.pop        (pop),
		.res        (res)
	);

	assign frame_valid       = res.frame_valid;
	assign command_one       = res.payload[0];
	assign command_two       = res.payload[1];
	assign speed_right       = res.payload[2];
	assign speed_left        = res.payload[3];
	assign battery_voltage   = res.payload[4];
	assign board_temperature = res.payload[5];
	assign led_command       = res.payload[6];

endmodule
